FILE: rtl/core/gam_pkg.sv
// gam_pkg: shared constants, types and helpers of the glob alternatives matcher
// no dependencies
`timescale 1ns / 1ps
package gam_pkg;
	localparam int MAX_MASK_CHARS = 64;
	localparam int LEN_W = $clog2(MAX_MASK_CHARS + 1);
	localparam int CODE_W = 21;

	localparam logic [1:0] OP_MASK_CHAR = 2'd0;
	localparam logic [1:0] OP_NAME_CHAR = 2'd1;
	localparam logic [1:0] OP_EVAL = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [CODE_W-1:0] CH_STAR = CODE_W'(8'h2A);
	localparam logic [CODE_W-1:0] CH_QUEST = CODE_W'(8'h3F);
	localparam logic [CODE_W-1:0] CH_BAR = CODE_W'(8'h7C);
	localparam logic [CODE_W-1:0] CH_BANG = CODE_W'(8'h21);

	localparam int CFG_CASE_SENSITIVE = 0;
	localparam int CFG_ALL_MUST_MATCH = 1;

	// structure flags of one mask position
	typedef struct packed {
		logic elem;
		logic start;
		logic alt_end;
		logic end_inv;
	} cell_flags_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic feed;
		logic begun;
		logic fold_en;
	} cell_ctrl_t;

	function automatic logic [CODE_W-1:0] fold(input logic [CODE_W-1:0] c, input logic en);
		logic [CODE_W-1:0] r;
		r = c;
		if (en && c >= CODE_W'(8'h41) && c <= CODE_W'(8'h5A)) begin
			r = c + CODE_W'(8'h20);
		end
		return r;
	endfunction
endpackage

FILE: rtl/core/gam_if.sv
// gam_req_if / gam_rsp_if: valid-ready channels of the matcher
// depends on gam_pkg
`timescale 1ns / 1ps
interface gam_req_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [gam_pkg::CODE_W-1:0] code;
	modport source (output valid, output op, output code, input ready);
	modport sink (input valid, input op, input code, output ready);
endinterface

interface gam_rsp_if;
	logic valid;
	logic ready;
	logic is_match;
	modport source (output valid, output is_match, input ready);
	modport sink (input valid, input is_match, output ready);
endinterface

FILE: rtl/core/glob_alternatives_matcher.sv
// glob_alternatives_matcher: top level, mask loader, row of gam_cell and evaluation
// depends on gam_pkg, gam_if, gam_cell
//
// channel | dir | payload        | transfer when
// req     | in  | op, code       | req.valid & req.ready
// rsp     | out | is_match       | rsp.valid & rsp.ready
// cfg     | in  | cfg_idx, data  | cfg_we
//
// one item per cycle while req.ready is high; the nfa step ripples combinationally through the cell row
// an end item gives its result in the cycle after it is taken, from the output register
// req.ready drops only while a result waits and rsp.ready is low
// reset clears mask length, flags, nfa bits and the output register
`timescale 1ns / 1ps
module glob_alternatives_matcher (
	input  logic clk,
	input  logic arst_n,
	gam_req_if.sink req,
	gam_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic cfg_data
);
	localparam int N = gam_pkg::MAX_MASK_CHARS;

	logic case_sens_q, all_q;
	logic [gam_pkg::LEN_W-1:0] len_q;
	logic at_start_q, inv_q, begun_q;
	logic act_end_q;
	logic rsp_valid_q, rsp_match_q;

	logic acc, do_wr, do_clr;
	gam_pkg::cell_flags_t wr_flags;
	gam_pkg::cell_ctrl_t ctrl;
	logic [gam_pkg::CODE_W-1:0] fc;
	logic [N:0] init_c, adv_c, pass_c;
	logic [N:0] cur_all;
	logic [N-1:0] hit, fail;
	gam_pkg::cell_flags_t flags [N];
	logic fin_r, any_r, all_r, match;

	assign req.ready = ~rsp_valid_q | rsp.ready;
	assign acc = req.valid & req.ready;
	assign do_wr = acc && req.op == gam_pkg::OP_MASK_CHAR
		&& len_q != gam_pkg::LEN_W'(N);
	assign do_clr = acc && req.op == gam_pkg::OP_CLEAR;

	assign ctrl.feed = acc && req.op == gam_pkg::OP_NAME_CHAR;
	assign ctrl.begun = begun_q;
	assign ctrl.fold_en = ~case_sens_q;
	assign fc = gam_pkg::fold(req.code, ~case_sens_q);

	// incremental scan of the appended character
	always_comb begin
		wr_flags = '0;
		if (at_start_q && req.code == gam_pkg::CH_BANG) begin
			wr_flags = '0;
		end else begin
			wr_flags.start = at_start_q;
			if (req.code == gam_pkg::CH_BAR) begin
				wr_flags.alt_end = 1'b1;
				wr_flags.end_inv = inv_q;
			end else begin
				wr_flags.elem = 1'b1;
			end
		end
	end

	assign init_c[0] = 1'b0;
	assign adv_c[0] = 1'b0;
	assign pass_c[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		gam_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.wr(do_wr && len_q == gam_pkg::LEN_W'(i)),
			.clr(do_clr),
			.wr_flags(wr_flags),
			.wr_code(req.code),
			.ctrl(ctrl),
			.name_fc(fc),
			.init_in(init_c[i]),
			.adv_in(adv_c[i]),
			.pass_in(pass_c[i]),
			.init_out(init_c[i+1]),
			.adv_out(adv_c[i+1]),
			.pass_out(pass_c[i+1]),
			.cur(cur_all[i]),
			.flags(flags[i])
		);
		assign hit[i] = flags[i].alt_end & (cur_all[i] ^ flags[i].end_inv);
		assign fail[i] = flags[i].alt_end & ~(cur_all[i] ^ flags[i].end_inv);
	end

	assign cur_all[N] = begun_q ? act_end_q : init_c[N];

	// closing alternative at the mask end, when one is open
	assign fin_r = cur_all[len_q] ^ inv_q;
	assign any_r = (|hit) | (~at_start_q & fin_r);
	assign all_r = ~(|fail) & (at_start_q | fin_r);
	assign match = (len_q == '0) ? ~all_q : (all_q ? all_r : any_r);

	assign rsp.valid = rsp_valid_q;
	assign rsp.is_match = rsp_match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_sens_q <= 1'b0;
			all_q <= 1'b0;
			len_q <= '0;
			at_start_q <= 1'b1;
			inv_q <= 1'b0;
			begun_q <= 1'b0;
			act_end_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_match_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == 1'(gam_pkg::CFG_CASE_SENSITIVE)) begin
					case_sens_q <= cfg_data;
				end else begin
					all_q <= cfg_data;
				end
			end
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (acc) begin
				case (req.op)
					gam_pkg::OP_MASK_CHAR: begin
						begun_q <= 1'b0;
						if (do_wr) begin
							len_q <= len_q + 1'b1;
							if (at_start_q && req.code == gam_pkg::CH_BANG) begin
								inv_q <= ~inv_q;
							end else if (req.code == gam_pkg::CH_BAR) begin
								inv_q <= 1'b0;
								at_start_q <= 1'b1;
							end else begin
								at_start_q <= 1'b0;
							end
						end
					end
					gam_pkg::OP_NAME_CHAR: begin
						begun_q <= 1'b1;
						act_end_q <= adv_c[N] | pass_c[N];
					end
					gam_pkg::OP_EVAL: begin
						begun_q <= 1'b0;
						rsp_valid_q <= 1'b1;
						rsp_match_q <= match;
					end
					default: begin
						begun_q <= 1'b0;
						len_q <= '0;
						at_start_q <= 1'b1;
						inv_q <= 1'b0;
					end
				endcase
			end
		end
	end

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= gam_pkg::LEN_W'(N)) else $error("mask length overflow");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		do_clr |=> len_q == '0 && at_start_q && !inv_q) else $error("clear failed");
	a_eval_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.op == gam_pkg::OP_EVAL |=> rsp_valid_q && !begun_q)
		else $error("end item gave no result");
	a_begun: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(begun_q) |-> $past(ctrl.feed)) else $error("name begun without character");
endmodule

FILE: rtl/core/gam_cell.sv
// gam_cell: one mask position, holds its character, structure flags and nfa bit
// depends on gam_pkg
`timescale 1ns / 1ps
module gam_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  logic clr,
	input  gam_pkg::cell_flags_t wr_flags,
	input  logic [gam_pkg::CODE_W-1:0] wr_code,
	input  gam_pkg::cell_ctrl_t ctrl,
	input  logic [gam_pkg::CODE_W-1:0] name_fc,
	input  logic init_in,
	input  logic adv_in,
	input  logic pass_in,
	output logic init_out,
	output logic adv_out,
	output logic pass_out,
	output logic cur,
	output gam_pkg::cell_flags_t flags
);
	logic [gam_pkg::CODE_W-1:0] ch_q;
	gam_pkg::cell_flags_t flags_q;
	logic act_q;
	logic is_star, is_quest, eq, init_pos, nxt, closed;

	assign is_star = ch_q == gam_pkg::CH_STAR;
	assign is_quest = ch_q == gam_pkg::CH_QUEST;
	assign eq = gam_pkg::fold(ch_q, ctrl.fold_en) == name_fc;

	// closure of the start set
	assign init_pos = flags_q.start | init_in;
	assign init_out = init_pos & flags_q.elem & is_star;

	assign cur = ctrl.begun ? act_q : init_pos;
	assign nxt = (cur & flags_q.elem & is_star) | adv_in;
	assign closed = nxt | pass_in;
	assign pass_out = closed & flags_q.elem & is_star;
	assign adv_out = cur & flags_q.elem & ~is_star & (is_quest | eq);
	assign flags = flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			act_q <= 1'b0;
		end else begin
			if (clr) begin
				flags_q <= '0;
			end else if (wr) begin
				flags_q <= wr_flags;
			end
			if (ctrl.feed) begin
				act_q <= closed;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ch_q <= wr_code;
		end
	end
endmodule
